@@ hdl/tlwp_pkg.sv @@
// ----------------------------------------------------------------------------
// tlwp_pkg: shared types and constants for the token lexer
// Token codes, position widths, the result word and byte classes.
// ----------------------------------------------------------------------------
package tlwp_pkg;

  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int LEN_BITS    = 16;

  // result queue
  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;
  localparam int QCNT_W   = 3;

  localparam logic [LINE_BITS-1:0]   LINE_TOP   = '1;
  localparam logic [LINE_BITS-1:0]   LINE_ONE   = {{(LINE_BITS-1){1'b0}}, 1'b1};
  localparam logic [COLUMN_BITS-1:0] COLUMN_TOP = '1;
  localparam logic [COLUMN_BITS-1:0] COLUMN_ONE = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
  localparam logic [LEN_BITS-1:0]    LEN_TOP    = '1;
  localparam logic [LEN_BITS-1:0]    LEN_ONE    = {{(LEN_BITS-1){1'b0}}, 1'b1};

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;

  // register indexes
  localparam logic REG_FIRST_LINE   = 1'b0;
  localparam logic REG_FIRST_COLUMN = 1'b1;

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_NUMERIC = 3'd1,
    KIND_NEWLINE = 3'd2,
    KIND_HASH    = 3'd3,
    KIND_COLON   = 3'd4,
    KIND_COMMA   = 3'd5,
    KIND_UNKNOWN = 3'd6
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t              kind;
    logic [LINE_BITS-1:0]   begin_line;
    logic [COLUMN_BITS-1:0] begin_column;
    logic [LINE_BITS-1:0]   finish_line;
    logic [COLUMN_BITS-1:0] finish_column;
    logic [LEN_BITS-1:0]    length;
    logic [7:0]             byte_val;
    logic                   last;
  } tok_res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_run_byte(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
           (b == CH_UNDERSCORE) || (b == CH_HYPHEN);
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] b);
    tok_kind_t k;
    case (b)
      CH_NEWLINE: k = KIND_NEWLINE;
      CH_HASH:    k = KIND_HASH;
      CH_COLON:   k = KIND_COLON;
      CH_COMMA:   k = KIND_COMMA;
      default:    k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/tlwp_step.sv @@
// ----------------------------------------------------------------------------
// tlwp_step: per-byte lexer step
// Holds run and position state; turns one byte into up to two results.
// ----------------------------------------------------------------------------
module tlwp_step import tlwp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic [7:0] byte_in,
  input  logic      end_of_text,
  input  logic      first_line,
  input  logic      first_column,
  output logic      flush_valid,
  output tok_res_t  flush_res,
  output logic      single_valid,
  output tok_res_t  single_res
);

  logic                   in_run_r, in_run_nxt;
  logic                   run_num_r, run_num_nxt;
  logic [LEN_BITS-1:0]    run_len_r, run_len_nxt;
  logic [7:0]             run_last_r, run_last_nxt;
  logic [LINE_BITS-1:0]   run_sl_r, run_sl_nxt;
  logic [COLUMN_BITS-1:0] run_sc_r, run_sc_nxt;
  logic [LINE_BITS-1:0]   cur_line_r, cur_line_nxt;
  logic [COLUMN_BITS-1:0] cur_col_r, cur_col_nxt;

  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_col;
  logic [LINE_BITS-1:0]   adv_line;
  logic [COLUMN_BITS-1:0] adv_col;

  assign start_line = {{(LINE_BITS-1){1'b0}}, first_line};
  assign start_col  = {{(COLUMN_BITS-1){1'b0}}, first_column};

  // position after the current byte
  always_comb begin
    if (byte_in == CH_NEWLINE) begin
      adv_line = (cur_line_r == LINE_TOP) ? cur_line_r : cur_line_r + LINE_ONE;
      adv_col  = start_col;
    end else begin
      adv_line = cur_line_r;
      adv_col  = (cur_col_r == COLUMN_TOP) ? cur_col_r : cur_col_r + COLUMN_ONE;
    end
  end

  always_comb begin
    in_run_nxt   = in_run_r;
    run_num_nxt  = run_num_r;
    run_len_nxt  = run_len_r;
    run_last_nxt = run_last_r;
    run_sl_nxt   = run_sl_r;
    run_sc_nxt   = run_sc_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    flush_valid  = 1'b0;
    single_valid = 1'b0;

    flush_res.kind          = run_num_r ? KIND_NUMERIC : KIND_IDENT;
    flush_res.begin_line    = run_sl_r;
    flush_res.begin_column  = run_sc_r;
    flush_res.finish_line   = cur_line_r;
    flush_res.finish_column = cur_col_r;
    flush_res.length        = run_len_r;
    flush_res.byte_val      = run_last_r;
    flush_res.last          = 1'b1;

    single_res.kind          = single_kind(byte_in);
    single_res.begin_line    = cur_line_r;
    single_res.begin_column  = cur_col_r;
    single_res.finish_line   = adv_line;
    single_res.finish_column = adv_col;
    single_res.length        = LEN_ONE;
    single_res.byte_val      = byte_in;
    single_res.last          = 1'b1;

    if (end_of_text) begin
      flush_valid  = in_run_r;
      cur_line_nxt = start_line;
      cur_col_nxt  = start_col;
    end else if (in_run_r && is_run_byte(byte_in)) begin
      run_len_nxt  = (run_len_r == LEN_TOP) ? run_len_r : run_len_r + LEN_ONE;
      run_num_nxt  = run_num_r & is_digit(byte_in);
      run_last_nxt = byte_in;
      cur_line_nxt = adv_line;
      cur_col_nxt  = adv_col;
    end else begin
      flush_valid  = in_run_r;
      cur_line_nxt = adv_line;
      cur_col_nxt  = adv_col;
      if (byte_in == CH_SPACE || byte_in == CH_TAB) begin
        single_valid = 1'b0;
      end else if (is_run_byte(byte_in)) begin
        in_run_nxt   = 1'b1;
        run_num_nxt  = is_digit(byte_in) || (byte_in == CH_HYPHEN);
        run_len_nxt  = LEN_ONE;
        run_last_nxt = byte_in;
        run_sl_nxt   = cur_line_r;
        run_sc_nxt   = cur_col_r;
      end else begin
        single_valid = 1'b1;
      end
    end

    // a flushed run that is not followed by a new run start is cleared
    if (flush_valid && !(!end_of_text && is_run_byte(byte_in))) begin
      in_run_nxt   = 1'b0;
      run_num_nxt  = 1'b1;
      run_len_nxt  = '0;
      run_last_nxt = '0;
      run_sl_nxt   = '0;
      run_sc_nxt   = '0;
    end

    flush_res.last = !single_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r   <= 1'b0;
      run_num_r  <= 1'b1;
      run_len_r  <= '0;
      run_last_r <= '0;
      run_sl_r   <= '0;
      run_sc_r   <= '0;
      cur_line_r <= start_line;
      cur_col_r  <= start_col;
    end else if (step) begin
      in_run_r   <= in_run_nxt;
      run_num_r  <= run_num_nxt;
      run_len_r  <= run_len_nxt;
      run_last_r <= run_last_nxt;
      run_sl_r   <= run_sl_nxt;
      run_sc_r   <= run_sc_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
    end
  end

endmodule

@@ hdl/tlwp_outq.sv @@
// ----------------------------------------------------------------------------
// tlwp_outq: result queue
// Four-entry queue; takes up to two results a cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
module tlwp_outq import tlwp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_a,
  input  tok_res_t data_a,
  input  logic     push_b,
  input  tok_res_t data_b,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output tok_res_t out_data
);

  tok_res_t            mem_r [QDEPTH];
  logic [QAW-1:0]      head_r, head_nxt;
  logic [QAW-1:0]      tail_r, tail_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [QAW-1:0]      addr_b;
  logic                pop;
  logic [QCNT_W-1:0]   n_push;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[head_r];
  assign pop       = out_valid && out_ready;
  // two free entries needed before a byte is stepped
  assign room      = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign n_push    = QCNT_W'(push_a) + QCNT_W'(push_b);
  assign addr_b    = push_a ? tail_r + QAW'(1) : tail_r;

  always_comb begin
    tail_nxt = tail_r + n_push[QAW-1:0];
    head_nxt = pop ? head_r + QAW'(1) : head_r;
    cnt_nxt  = cnt_r + n_push - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[tail_r] <= data_a;
    end
    if (push_b) begin
      mem_r[addr_b] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ hdl/token_lexer_with_positions.sv @@
// ----------------------------------------------------------------------------
// token_lexer_with_positions: byte-stream lexer with source positions
// Splits a byte stream into identifier, numeric and one-byte tokens and
// reports each token's begin/finish line and column, length and byte.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------
//  in_     | input     | in_valid / in_ready   | byte_in, end_of_text
//  out_    | output    | out_valid / out_ready | one token record
//  cfg_    | input     | APB, pready tied high | first_line @0, first_column @4
//
//  One byte a cycle while the queue has room: an accepted word waits in
//  the input register, is stepped into the result queue, and its first
//  result shows the cycle after. A byte that both closes a run and forms
//  a token yields two words, so the output side then sets the pace at one
//  result word a cycle. The step waits for two free entries in the
//  four-entry result queue; in_ready drops only while the input register
//  holds a word that cannot step. Reset (rst_n low, synchronous) empties
//  the queue, clears the run and sets the position and both registers to one.
//
module token_lexer_with_positions import tlwp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte_in,
  input  logic                   in_end_of_text,
  // result words
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_token_kind,
  output logic [LINE_BITS-1:0]   out_begin_line,
  output logic [COLUMN_BITS-1:0] out_begin_column,
  output logic [LINE_BITS-1:0]   out_finish_line,
  output logic [COLUMN_BITS-1:0] out_finish_column,
  output logic [LEN_BITS-1:0]    out_token_length,
  output logic [7:0]             out_single_byte,
  output logic                   out_last_of_run,
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  // input register
  logic       ivalid_r, ivalid_nxt;
  logic [7:0] byte_r;
  logic       eot_r;

  // configuration registers
  logic first_line_r;
  logic first_column_r;
  logic cfg_wr;
  logic cfg_sel;

  logic     step;
  logic     room;
  logic     flush_valid;
  logic     single_valid;
  tok_res_t flush_res;
  tok_res_t single_res;
  tok_res_t head;

  // --- configuration port: zero-wait APB, one bit per register
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_sel)
      REG_FIRST_LINE:   cfg_prdata = {31'b0, first_line_r};
      REG_FIRST_COLUMN: cfg_prdata = {31'b0, first_column_r};
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r   <= 1'b1;
      first_column_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_FIRST_LINE:   first_line_r   <= cfg_pwdata[0];
        REG_FIRST_COLUMN: first_column_r <= cfg_pwdata[0];
        default:          first_line_r   <= first_line_r;
      endcase
    end
  end

  // --- input register: advance when empty or when the held word steps
  assign step     = ivalid_r && room;
  assign in_ready = !ivalid_r || step;

  always_comb begin
    ivalid_nxt = ivalid_r;
    if (in_valid && in_ready) begin
      ivalid_nxt = 1'b1;
    end else if (step) begin
      ivalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r <= 1'b0;
    end else begin
      ivalid_r <= ivalid_nxt;
    end
  end

  // payload: hold unless a new word lands
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
      eot_r  <= in_end_of_text;
    end
  end

  // --- lexer step: run state, position and token records
  tlwp_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .byte_in      (byte_r),
    .end_of_text  (eot_r),
    .first_line   (first_line_r),
    .first_column (first_column_r),
    .flush_valid  (flush_valid),
    .flush_res    (flush_res),
    .single_valid (single_valid),
    .single_res   (single_res)
  );

  // --- result queue: flushed run first, then the one-byte token
  tlwp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (step && flush_valid),
    .data_a    (flush_res),
    .push_b    (step && single_valid),
    .data_b    (single_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_token_kind    = head.kind;
  assign out_begin_line    = head.begin_line;
  assign out_begin_column  = head.begin_column;
  assign out_finish_line   = head.finish_line;
  assign out_finish_column = head.finish_column;
  assign out_token_length  = head.length;
  assign out_single_byte   = head.byte_val;
  assign out_last_of_run   = head.last;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: token lexer testbench
// Streams byte words through token_lexer_with_positions under random input
// and output stalls. A behavioral lexer predicts every token record, and each
// record that leaves the block is checked field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_top;
  import tlwp_pkg::*;

  // character range bounds for classification
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;

  // one word on the input channel
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_byte_in = 8'h00;
  logic                   in_end_of_text = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             out_token_kind;
  logic [LINE_BITS-1:0]   out_begin_line;
  logic [COLUMN_BITS-1:0] out_begin_column;
  logic [LINE_BITS-1:0]   out_finish_line;
  logic [COLUMN_BITS-1:0] out_finish_column;
  logic [LEN_BITS-1:0]    out_token_length;
  logic [7:0]             out_single_byte;
  logic                   out_last_of_run;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [2:0]             cfg_paddr = 3'd0;
  logic [31:0]            cfg_pwdata = 32'd0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  token_lexer_with_positions dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_in        (in_byte_in),
    .in_end_of_text    (in_end_of_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_begin_line    (out_begin_line),
    .out_begin_column  (out_begin_column),
    .out_finish_line   (out_finish_line),
    .out_finish_column (out_finish_column),
    .out_token_length  (out_token_length),
    .out_single_byte   (out_single_byte),
    .out_last_of_run   (out_last_of_run),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // period 4: high 2, low 2
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Lexer prediction state. Mirrors the block: configuration bits, the open
  // run and the current position. Values here are the reset values.
  // --------------------------------------------------------------------------
  logic                   base_line = 1'b1;
  logic                   base_col = 1'b1;
  logic                   run_open = 1'b0;
  logic                   run_numeric = 1'b1;
  logic [LEN_BITS-1:0]    run_len = '0;
  logic [7:0]             run_last = 8'h00;
  logic [LINE_BITS-1:0]   run_line = '0;
  logic [COLUMN_BITS-1:0] run_col = '0;
  logic [LINE_BITS-1:0]   pos_line = LINE_ONE;
  logic [COLUMN_BITS-1:0] pos_col = COLUMN_ONE;

  tok_res_t   expected_tokens[$];
  text_word_t pending_words[$];
  text_word_t next_word;
  logic       in_fire = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         mismatch_count = 0;

  function automatic logic digit_char(input logic [7:0] b);
    return (b >= CH_DIGIT_LO) && (b <= CH_DIGIT_HI);
  endfunction

  function automatic logic ident_char(input logic [7:0] b);
    return digit_char(b) ||
           ((b >= CH_UPPER_LO) && (b <= CH_UPPER_HI)) ||
           ((b >= CH_LOWER_LO) && (b <= CH_LOWER_HI)) ||
           (b == CH_UNDERSCORE) || (b == CH_HYPHEN);
  endfunction

  // Move the position past one byte; newline returns to the base column.
  task automatic advance_pos(input logic [7:0] b);
    if (b == CH_NEWLINE) begin
      if (pos_line != LINE_TOP) pos_line = pos_line + LINE_ONE;
      pos_col = COLUMN_BITS'(base_col);
    end else if (pos_col != COLUMN_TOP) begin
      pos_col = pos_col + COLUMN_ONE;
    end
  endtask

  // Emit the open run, ending at the current position, and clear it.
  task automatic close_run(output tok_res_t t);
    t.kind          = run_numeric ? KIND_NUMERIC : KIND_IDENT;
    t.begin_line    = run_line;
    t.begin_column  = run_col;
    t.finish_line   = pos_line;
    t.finish_column = pos_col;
    t.length        = run_len;
    t.byte_val      = run_last;
    t.last          = 1'b0;
    run_open    = 1'b0;
    run_numeric = 1'b1;
    run_len     = '0;
    run_last    = 8'h00;
    run_line    = '0;
    run_col     = '0;
  endtask

  // Step the lexer by one accepted word and queue the records it causes.
  task automatic lex_word(input logic [7:0] b, input logic eot);
    tok_res_t made[2];
    int       n;
    int       i;
    n = 0;
    if (eot) begin
      if (run_open) begin
        close_run(made[n]);
        n++;
      end
      pos_line = LINE_BITS'(base_line);
      pos_col  = COLUMN_BITS'(base_col);
    end else if (run_open && ident_char(b)) begin
      if (run_len != LEN_TOP) run_len = run_len + LEN_ONE;
      if (!digit_char(b)) run_numeric = 1'b0;
      run_last = b;
      advance_pos(b);
    end else begin
      if (run_open) begin
        close_run(made[n]);
        n++;
      end
      if ((b == CH_SPACE) || (b == CH_TAB)) begin
        advance_pos(b);
      end else if (ident_char(b)) begin
        run_open    = 1'b1;
        run_numeric = digit_char(b) || (b == CH_HYPHEN);
        run_len     = LEN_ONE;
        run_last    = b;
        run_line    = pos_line;
        run_col     = pos_col;
        advance_pos(b);
      end else begin
        case (b)
          CH_NEWLINE: made[n].kind = KIND_NEWLINE;
          CH_HASH:    made[n].kind = KIND_HASH;
          CH_COLON:   made[n].kind = KIND_COLON;
          CH_COMMA:   made[n].kind = KIND_COMMA;
          default:    made[n].kind = KIND_UNKNOWN;
        endcase
        made[n].begin_line   = pos_line;
        made[n].begin_column = pos_col;
        advance_pos(b);
        made[n].finish_line   = pos_line;
        made[n].finish_column = pos_col;
        made[n].length        = LEN_ONE;
        made[n].byte_val      = b;
        made[n].last          = 1'b0;
        n++;
      end
    end
    // flag the final record of this word
    if (n > 0) made[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_tokens = {expected_tokens, made[i]};
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  task automatic check_token();
    tok_res_t want;
    if (expected_tokens.size() == 0) begin
      flag_mismatch("token with none pending, kind", 0, 32'(out_token_kind));
    end else begin
      want = expected_tokens.pop_front();
      if (out_token_kind != want.kind)
        flag_mismatch("token_kind", 32'(want.kind), 32'(out_token_kind));
      if (out_begin_line != want.begin_line)
        flag_mismatch("begin_line", 32'(want.begin_line), 32'(out_begin_line));
      if (out_begin_column != want.begin_column)
        flag_mismatch("begin_column", 32'(want.begin_column), 32'(out_begin_column));
      if (out_finish_line != want.finish_line)
        flag_mismatch("finish_line", 32'(want.finish_line), 32'(out_finish_line));
      if (out_finish_column != want.finish_column)
        flag_mismatch("finish_column", 32'(want.finish_column),
                      32'(out_finish_column));
      if (out_token_length != want.length)
        flag_mismatch("token_length", 32'(want.length), 32'(out_token_length));
      if (out_single_byte != want.byte_val)
        flag_mismatch("single_byte", 32'(want.byte_val), 32'(out_single_byte));
      if (out_last_of_run != want.last)
        flag_mismatch("last_of_run", 32'(want.last), 32'(out_last_of_run));
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Predict from each
  // accepted input word, check each accepted result word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) lex_word(in_byte_in, in_end_of_text);
    if (rst_n && out_valid && out_ready) check_token();
  end

  // --------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Hold a word until taken, then
  // either present the next pending word or idle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && !(in_valid && !in_fire)) begin
      if ((pending_words.size() != 0) && ($urandom_range(99) >= send_idle_pct)) begin
        next_word = pending_words.pop_front();
        in_valid       <= 1'b1;
        in_byte_in     <= next_word.ch;
        in_end_of_text <= next_word.eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    text_word_t w;
    w.ch  = b;
    w.eot = 1'b0;
    pending_words = {pending_words, w};
  endtask

  // end marker; the byte rides along and must be ignored
  task automatic push_end(input logic [7:0] b);
    text_word_t w;
    w.ch  = b;
    w.eot = 1'b1;
    pending_words = {pending_words, w};
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] random_ident_char();
    case ($urandom_range(4))
      0:       return 8'($urandom_range(CH_UPPER_HI, CH_UPPER_LO));
      1:       return 8'($urandom_range(CH_DIGIT_HI, CH_DIGIT_LO));
      2:       return $urandom_range(1) ? CH_UNDERSCORE : CH_HYPHEN;
      default: return 8'($urandom_range(CH_LOWER_HI, CH_LOWER_LO));
    endcase
  endfunction

  // One source text: mostly well-formed tokens with random content, a little
  // noise and the odd early end marker, closed by an end marker.
  task automatic push_random_text();
    int pieces;
    int len;
    int i;
    int j;
    pieces = $urandom_range(12, 1);
    for (i = 0; i < pieces; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          len = $urandom_range(8, 1);
          for (j = 0; j < len; j++) push_byte(random_ident_char());
        end
        2: begin
          if ($urandom_range(1)) push_byte(CH_HYPHEN);
          len = $urandom_range(5, 1);
          for (j = 0; j < len; j++)
            push_byte(8'($urandom_range(CH_DIGIT_HI, CH_DIGIT_LO)));
        end
        3: begin
          len = $urandom_range(3, 1);
          for (j = 0; j < len; j++) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        end
        4: begin
          case ($urandom_range(2))
            0:       push_byte(CH_HASH);
            1:       push_byte(CH_COLON);
            default: push_byte(CH_COMMA);
          endcase
        end
        5: push_byte(CH_NEWLINE);
        6: push_byte(8'($urandom_range(255)));
        7: push_end(8'($urandom_range(255)));
        default: push_byte(CH_SPACE);
      endcase
    end
    push_end(8'($urandom_range(255)));
  endtask

  task automatic fill_random(input int count);
    while (pending_words.size() < count) push_random_text();
  endtask

  // Register write in setup and access phases; the block is idle whenever this runs.
  task automatic write_reg(input logic idx, input logic val);
    logic [31:0] data;
    data    = $urandom();
    data[0] = val;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_FIRST_LINE) base_line = val;
    else base_col = val;
  endtask

  // Wait until every word is taken and every record has come back, then let
  // a word that causes no record finish its trip through the block.
  task automatic settle();
    do @(posedge clk);
    while ((pending_words.size() != 0) || in_valid || (expected_tokens.size() != 0));
    repeat (8) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every class of byte, runs closed each way, lone hyphen
    push_text("Az_9#");          // identifier broken by hash: two records
    push_byte(CH_HYPHEN);
    push_end(8'hFF);             // lone hyphen flushed by the end marker
    push_end(8'h00);             // end marker with nothing open
    push_text("-42 ");           // signed number closed by a space
    push_text("7-,");            // digit then hyphen is an identifier
    push_text("\t:");
    push_byte(8'h00);
    push_byte(8'h80);
    push_byte(8'hFF);
    push_text("z0\n");           // run broken by a newline
    push_end(8'h5A);
    settle();

    // low sender idle, heavy receiver stalls; both bases at zero
    write_reg(REG_FIRST_LINE, 1'b0);
    write_reg(REG_FIRST_COLUMN, 1'b0);
    send_idle_pct = 11;
    recv_idle_pct = 83;
    fill_random(170);
    settle();

    // swap the stall pattern
    write_reg(REG_FIRST_LINE, 1'b1);
    send_idle_pct = 83;
    recv_idle_pct = 11;
    fill_random(170);
    settle();

    // full rate, then a short tail of one-byte tokens
    write_reg(REG_FIRST_LINE, 1'b0);
    write_reg(REG_FIRST_COLUMN, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(170);
    push_text("#  :\nq");
    push_end(8'h00);
    settle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog: ends a test that hangs
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
